@@ rtl/core/dmc_pkg.sv @@
// Shared constants and register codes for the direct-mapped cache tag model.
package dmc_pkg;

	localparam int unsigned MAX_SETS_DFLT = 1024;

	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned TAG_W   = 30;
	localparam int unsigned CYC_W   = 16;
	localparam int unsigned CNT_W   = 32;
	localparam int unsigned TOT_W   = 48;
	localparam int unsigned CFG_W   = 4;
	localparam int unsigned CFG_IDX_W = 2;

	// Tag RAM word: valid, dirty, tag
	localparam int unsigned ENTRY_W = TAG_W + 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_THROUGH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS     = 2'd3;

	// Register reset values
	localparam logic       RST_WRITE_THROUGH  = 1'b0;
	localparam logic       RST_WRITE_ALLOCATE = 1'b1;
	localparam logic [3:0] RST_OFFSET_BITS    = 4'd4;
	localparam logic [3:0] RST_INDEX_BITS     = 4'd8;

	// Offset clamp range
	localparam logic [3:0] OFFSET_MIN = 4'd2;
	localparam logic [3:0] OFFSET_MAX = 4'd10;
	localparam logic [3:0] INDEX_CAP  = 4'd10;

	// Cost of one word moved to or from memory; a block moves 2^(ob-2) words
	localparam logic [CYC_W-1:0] WORD_XFER_COST = 16'd100;

endpackage

@@ rtl/core/dmc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module dmc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/direct_mapped_cache_tag_model_top.sv @@
// Top level of the direct-mapped cache tag model: tag RAM control, cost and counters.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_valid / in_stall | action, address
//  out     | output    | out_valid/out_stall | is_hit, wrote_back, access_cycles,
//          |           |                     | load_hits .. store_misses, total_cycles
//  cfg     | input     | cfg_we (no wait)    | cfg_index, cfg_data
//
// Cycles: two per item. The accepting edge issues the tag RAM read; the next edge
// (lookup) takes the registered read data, decides hit / eviction, writes the line
// back and loads the result register. The single-port read-modify-write of the tag
// RAM sets the figure: a new item is taken only once the previous write-back is done.
// Reset: after arst_n rises a clearing pass writes every set invalid and clean,
// 2^min(10, floor(log2 MAX_SETS)) cycles (1024 at the default); no transfer in meanwhile.
// Stalls: a waiting result does not block intake; one more item may be read from the
// tag RAM and holds in lookup until the result register is free.
module direct_mapped_cache_tag_model_top #(
	parameter int unsigned MAX_SETS = dmc_pkg::MAX_SETS_DFLT
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_we,
	input  logic [dmc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dmc_pkg::CFG_W-1:0]           cfg_data,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic [dmc_pkg::ADDR_W-1:0]          address,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                is_hit,
	output logic                                wrote_back,
	output logic [dmc_pkg::CYC_W-1:0]           access_cycles,
	output logic [dmc_pkg::CNT_W-1:0]           load_hits,
	output logic [dmc_pkg::CNT_W-1:0]           load_misses,
	output logic [dmc_pkg::CNT_W-1:0]           store_hits,
	output logic [dmc_pkg::CNT_W-1:0]           store_misses,
	output logic [dmc_pkg::TOT_W-1:0]           total_cycles
);

	// Largest usable index width: min(10, floor(log2 MAX_SETS))
	localparam int unsigned IDX_FIT = $clog2(MAX_SETS + 1) - 1;
	localparam int unsigned IDX_LIM = (IDX_FIT > 10) ? 10 : IDX_FIT;
	localparam int unsigned DEPTH   = 1 << IDX_LIM;
	localparam int unsigned SET_W   = (IDX_LIM > 0) ? IDX_LIM : 1;
	localparam logic [3:0]  IDX_LIM_C = 4'(IDX_LIM);
	localparam logic [SET_W-1:0] LAST_SET = SET_W'(DEPTH - 1);

	typedef struct packed {
		logic                       valid;
		logic                       dirty;
		logic [dmc_pkg::TAG_W-1:0]  tag;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_LOOKUP = 3'b100
	} state_t;

	state_t state_q;
	logic [SET_W-1:0] clr_q;

	// Configuration registers
	logic       write_through_q;
	logic       write_allocate_q;
	logic [3:0] offset_bits_q;
	logic [3:0] index_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_through_q  <= dmc_pkg::RST_WRITE_THROUGH;
			write_allocate_q <= dmc_pkg::RST_WRITE_ALLOCATE;
			offset_bits_q    <= dmc_pkg::RST_OFFSET_BITS;
			index_bits_q     <= dmc_pkg::RST_INDEX_BITS;
		end else if (cfg_we) begin
			case (cfg_index)
				dmc_pkg::CFG_WRITE_THROUGH:  write_through_q  <= cfg_data[0];
				dmc_pkg::CFG_WRITE_ALLOCATE: write_allocate_q <= cfg_data[0];
				dmc_pkg::CFG_OFFSET_BITS:    offset_bits_q    <= cfg_data;
				dmc_pkg::CFG_INDEX_BITS:     index_bits_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Geometry: clamped offset and index widths
	logic [3:0] ob;
	logic [3:0] ib;
	logic [dmc_pkg::ADDR_W-1:0] blk;
	logic [dmc_pkg::ADDR_W-1:0] tag_full;
	logic [SET_W-1:0] set_mask;
	logic [SET_W-1:0] in_set;
	logic [dmc_pkg::CYC_W-1:0] xfer;

	always_comb begin
		if (offset_bits_q < dmc_pkg::OFFSET_MIN) begin
			ob = dmc_pkg::OFFSET_MIN;
		end else if (offset_bits_q > dmc_pkg::OFFSET_MAX) begin
			ob = dmc_pkg::OFFSET_MAX;
		end else begin
			ob = offset_bits_q;
		end
		ib       = (index_bits_q > IDX_LIM_C) ? IDX_LIM_C : index_bits_q;
		blk      = address >> ob;
		tag_full = blk >> ib;
		set_mask = ~({SET_W{1'b1}} << ib);
		in_set   = blk[SET_W-1:0] & set_mask;
		xfer     = dmc_pkg::WORD_XFER_COST << (ob - dmc_pkg::OFFSET_MIN);
	end

	// Item held across the RAM read
	logic                       action_s1;
	logic [dmc_pkg::TAG_W-1:0]  tag_s1;
	logic [SET_W-1:0]           set_s1;

	logic in_xfer;
	logic commit;
	logic out_valid_q;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign commit   = (state_q == ST_LOOKUP) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			action_s1 <= action;
			tag_s1    <= tag_full[dmc_pkg::TAG_W-1:0];
			set_s1    <= in_set;
		end
	end

	// Tag RAM
	entry_t     rd_entry;
	entry_t     wr_entry;
	logic       ram_we;
	logic [SET_W-1:0] ram_waddr;
	logic [dmc_pkg::ENTRY_W-1:0] ram_rdata;

	dmc_ram #(
		.WIDTH (dmc_pkg::ENTRY_W),
		.DEPTH (DEPTH)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.re    (in_xfer),
		.raddr (in_set),
		.rdata (ram_rdata)
	);

	assign rd_entry = entry_t'(ram_rdata);

	// Lookup decision
	logic hit;
	logic do_install;
	logic wb;
	logic pay_xfer;
	logic line_we;
	entry_t line_new;
	logic [dmc_pkg::CYC_W-1:0] cost;

	always_comb begin
		hit        = rd_entry.valid && (rd_entry.tag == tag_s1);
		do_install = 1'b0;
		pay_xfer   = 1'b1;
		line_we    = 1'b0;
		line_new   = rd_entry;
		if (!action_s1) begin
			pay_xfer   = !hit;
			do_install = !hit;
		end else if (hit) begin
			pay_xfer = write_through_q;
			if (!write_through_q) begin
				line_we        = 1'b1;
				line_new.dirty = 1'b1;
			end
		end else begin
			do_install = write_allocate_q;
		end
		// Dirty marks left from write-back mode are ignored in write-through mode
		wb = do_install && rd_entry.valid && rd_entry.dirty && !write_through_q;
		if (do_install) begin
			line_we        = 1'b1;
			line_new.valid = 1'b1;
			line_new.dirty = action_s1 && !write_through_q;
			line_new.tag   = tag_s1;
		end
		cost = 16'd1 + (pay_xfer ? xfer : '0) + (wb ? xfer : '0);
	end

	// RAM write port: clearing pass, else write-back of the looked-up line
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			wr_entry  = '0;
		end else begin
			ram_we    = commit && line_we;
			ram_waddr = set_s1;
			wr_entry  = line_new;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SET) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// Result register
	logic                      is_hit_q;
	logic                      wrote_back_q;
	logic [dmc_pkg::CYC_W-1:0] access_cycles_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			is_hit_q        <= hit;
			wrote_back_q    <= wb;
			access_cycles_q <= cost;
		end
	end

	// Saturating counters; they change only on commit, so they hold while a result waits
	logic [dmc_pkg::CNT_W-1:0] load_hit_q;
	logic [dmc_pkg::CNT_W-1:0] load_miss_q;
	logic [dmc_pkg::CNT_W-1:0] store_hit_q;
	logic [dmc_pkg::CNT_W-1:0] store_miss_q;
	logic [dmc_pkg::TOT_W-1:0] total_q;
	logic [dmc_pkg::TOT_W:0]   total_sum;

	assign total_sum = {1'b0, total_q} + (dmc_pkg::TOT_W + 1)'(cost);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_hit_q   <= '0;
			load_miss_q  <= '0;
			store_hit_q  <= '0;
			store_miss_q <= '0;
			total_q      <= '0;
		end else if (commit) begin
			if (!action_s1 && hit && (load_hit_q != '1)) begin
				load_hit_q <= load_hit_q + 1'b1;
			end
			if (!action_s1 && !hit && (load_miss_q != '1)) begin
				load_miss_q <= load_miss_q + 1'b1;
			end
			if (action_s1 && hit && (store_hit_q != '1)) begin
				store_hit_q <= store_hit_q + 1'b1;
			end
			if (action_s1 && !hit && (store_miss_q != '1)) begin
				store_miss_q <= store_miss_q + 1'b1;
			end
			total_q <= total_sum[dmc_pkg::TOT_W] ? '1 : total_sum[dmc_pkg::TOT_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign is_hit        = is_hit_q;
	assign wrote_back    = wrote_back_q;
	assign access_cycles = access_cycles_q;
	assign load_hits     = load_hit_q;
	assign load_misses   = load_miss_q;
	assign store_hits    = store_hit_q;
	assign store_misses  = store_miss_q;
	assign total_cycles  = total_q;

endmodule

@@ rtl/core/dmc_checker.sv @@
// Port-level checker for the cache tag model, bound to the top level.
module dmc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              is_hit,
	input logic                              wrote_back,
	input logic [dmc_pkg::CYC_W-1:0]         access_cycles,
	input logic [dmc_pkg::CNT_W-1:0]         load_hits,
	input logic [dmc_pkg::TOT_W-1:0]         total_cycles
);

	// Waiting result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(access_cycles)
			&& $stable(is_hit) && $stable(total_cycles))
		else $error("stalled result changed");

	// Eviction only happens on a miss
	a_wb_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wrote_back |-> !is_hit)
		else $error("write-back reported on a hit");

	// Every access costs at least the cache access itself
	a_cost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> access_cycles != '0)
		else $error("zero access cost");

	// Running totals never fall
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		##1 total_cycles >= $past(total_cycles))
		else $error("cycle total decreased");

	a_lhit_mono: assert property (@(posedge clk) disable iff (!arst_n)
		##1 load_hits >= $past(load_hits))
		else $error("load hit count decreased");

endmodule

bind direct_mapped_cache_tag_model_top dmc_checker u_dmc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.is_hit        (is_hit),
	.wrote_back    (wrote_back),
	.access_cycles (access_cycles),
	.load_hits     (load_hits),
	.total_cycles  (total_cycles)
);
